FILE: rtl/bbc_pkg.sv
// Shared types and constants of the bracket balance checker.
package bbc_pkg;

  // Raw byte width of one input word
  localparam int unsigned SYM_W = 8;

  // Bracket characters
  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;  // (
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;  // )
  localparam logic [SYM_W-1:0] CH_LBRACE = 8'h7B;  // {
  localparam logic [SYM_W-1:0] CH_RBRACE = 8'h7D;  // }
  localparam logic [SYM_W-1:0] CH_LBRACK = 8'h5B;  // [
  localparam logic [SYM_W-1:0] CH_RBRACK = 8'h5D;  // ]

  // Stack entry codes, one per bracket kind
  typedef logic [1:0] br_code_t;
  localparam br_code_t BR_NONE  = 2'd0;
  localparam br_code_t BR_PAREN = 2'd1;
  localparam br_code_t BR_BRACE = 2'd2;
  localparam br_code_t BR_BRACK = 2'd3;

  // Verdict codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_UNMATCHED = 3'd1;
  localparam status_t ST_MISMATCH  = 3'd2;
  localparam status_t ST_UNCLOSED  = 3'd3;
  localparam status_t ST_OVERFLOW  = 3'd4;

  // Stack operation chosen by the front end
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } op_t;

  // Decoded word passed from front to back
  typedef struct packed {
    op_t      op;
    br_code_t code;
    logic     last;
  } cmd_t;

  // Map a raw byte onto a stack operation
  function automatic cmd_t classify(logic [SYM_W-1:0] sym, logic last);
    cmd_t c;
    c.op   = OP_NONE;
    c.code = BR_NONE;
    c.last = last;
    case (sym)
      CH_LPAREN: begin c.op = OP_PUSH; c.code = BR_PAREN; end
      CH_LBRACE: begin c.op = OP_PUSH; c.code = BR_BRACE; end
      CH_LBRACK: begin c.op = OP_PUSH; c.code = BR_BRACK; end
      CH_RPAREN: begin c.op = OP_POP;  c.code = BR_PAREN; end
      CH_RBRACE: begin c.op = OP_POP;  c.code = BR_BRACE; end
      CH_RBRACK: begin c.op = OP_POP;  c.code = BR_BRACK; end
      default: begin
        c.op   = OP_NONE;
        c.code = BR_NONE;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/bbc_if.sv
// Valid/ready channel interfaces for the input and result words.
interface bbc_in_if import bbc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, symbol, last, input ready);
  modport sink   (input valid, symbol, last, output ready);
endinterface

interface bbc_out_if import bbc_pkg::*;;
  logic    valid;
  logic    ready;
  logic    balanced;
  status_t status;

  modport source (output valid, balanced, status, input ready);
  modport sink   (input valid, balanced, status, output ready);
endinterface

FILE: rtl/bbc_front.sv
// Front end: decodes each input byte and buffers it in a two-entry queue.
module bbc_front import bbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bbc_in_if.sink     in_ch,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_ready
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  // Handshakes on both sides of the queue
  assign in_ch.ready = (cnt_r != 2'd2);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_cmd       = q_mem_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage, decoded on the way in
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= classify(in_ch.symbol, in_ch.last);
    end
  end

endmodule

FILE: rtl/bbc_back.sv
// Back end: bracket stack with cached top, error latch and result register.
module bbc_back import bbc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_ready,
  bbc_out_if.source  out_ch
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Entries below the top of stack; the top itself lives in top_r
  br_code_t          stk_mem [STACK_DEPTH];
  br_code_t          top_r, top_nxt;
  br_code_t          below_r;           // prefetched entry under the top
  logic [CW-1:0]     count_r, count_nxt;
  status_t           err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              balanced_r, balanced_nxt;
  status_t           status_r, status_nxt;
  logic              take;
  logic              we;
  logic [AW-1:0]     waddr, raddr;

  // Only a final word needs the result register free
  assign q_ready = !out_valid_r || out_ch.ready || !q_cmd.last;
  assign take    = q_valid && q_ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.balanced = balanced_r;
  assign out_ch.status   = status_r;

  // Stack step, verdict and clear on the final word
  always_comb begin
    logic [CW-1:0] cnt_p;
    status_t       err_p;
    status_t       verdict;
    cnt_p         = count_r;
    err_p         = err_r;
    verdict       = ST_OK;
    top_nxt       = top_r;
    we            = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    balanced_nxt  = balanced_r;
    status_nxt    = status_r;
    if (take && (err_r == ST_OK)) begin
      case (q_cmd.op)
        OP_PUSH: begin
          if (count_r == CW'(STACK_DEPTH)) begin
            err_p = ST_OVERFLOW;
          end else begin
            cnt_p   = count_r + CW'(1);
            top_nxt = q_cmd.code;
            we      = (count_r != '0);
          end
        end
        OP_POP: begin
          if (count_r == '0) begin
            err_p = ST_UNMATCHED;
          end else if (top_r == q_cmd.code) begin
            cnt_p   = count_r - CW'(1);
            top_nxt = below_r;
          end else begin
            err_p = ST_MISMATCH;
          end
        end
        default: begin
          cnt_p = count_r;
        end
      endcase
    end
    count_nxt = cnt_p;
    err_nxt   = err_p;
    if (take && q_cmd.last) begin
      if (err_p != ST_OK) begin
        verdict = err_p;
      end else if (cnt_p != '0) begin
        verdict = ST_UNCLOSED;
      end
      out_valid_nxt = 1'b1;
      balanced_nxt  = (verdict == ST_OK);
      status_nxt    = verdict;
      count_nxt     = '0;
      err_nxt       = ST_OK;
    end
  end

  // Old top goes below the new one; prefetch the entry under the next top
  assign waddr = AW'(count_r - CW'(1));
  assign raddr = AW'(count_nxt - CW'(2));

  always_ff @(posedge clk) begin
    if (we) begin
      stk_mem[waddr] <= top_r;
    end
    if (we && (waddr == raddr)) begin
      below_r <= top_r;
    end else begin
      below_r <= stk_mem[raddr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    balanced_r <= balanced_nxt;
    status_r   <= status_nxt;
  end

endmodule

FILE: rtl/bracket_balance_checker_top.sv
// Top level of the bracket balance checker.
// Takes one byte per cycle and sustains that rate while results are taken; a
// word with last set yields one registered verdict (balanced, status) after
// passing the front queue and then the result register. Bytes are decoded into
// push/pop commands and queued two deep. Only a final byte waits while an
// earlier verdict is still untaken; all other bytes keep flowing through the
// stack. The back end keeps the top of stack in a register and prefetches the
// entry beneath it from the stack RAM, so no push, pop or compare waits on a
// stack RAM read. The first error is held until the final byte; the final byte
// clears the stack for the next expression. No clearing pass after reset.
module bracket_balance_checker_top import bbc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bbc_in_if.sink    in_ch,
  bbc_out_if.source out_ch
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // Decode and buffer
  bbc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready)
  );

  // Stack and verdict
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/bbc_checker.sv
// Port-level checks for the bracket balance checker, bound to the top level.
module bbc_checker import bbc_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_ready,
  input logic    out_balanced,
  input status_t out_status
);

  // Balanced flag agrees with the status code
  a_bal_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_balanced == (out_status == ST_OK)))
    else $error("balanced flag disagrees with status");

  // Only defined verdict codes leave the block
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_UNMATCHED ||
                   out_status == ST_MISMATCH || out_status == ST_UNCLOSED ||
                   out_status == ST_OVERFLOW))
    else $error("undefined status code");

  // A stalled verdict word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_balanced)))
    else $error("result word changed while stalled");

  // Reset leaves no verdict pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_balanced (out_ch.balanced),
  .out_status   (out_ch.status)
);

FILE: dv/bracket_balance_checker_top_test.sv
// Self-checking testbench of the bracket balance checker: random expressions, verdict checking.
module bracket_balance_checker_top_test;
  import bbc_pkg::*;

  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One byte of an expression as offered on the input channel
  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } word_t;

  // Verdict as seen on the result channel
  typedef struct packed {
    logic    balanced;
    status_t status;
  } verdict_t;

  // Shape of a generated expression
  typedef enum {
    SHAPE_BALANCED,
    SHAPE_UNCLOSED,
    SHAPE_MISMATCH,
    SHAPE_UNMATCHED,
    SHAPE_OVERFLOW,
    SHAPE_NOISE
  } shape_t;

  logic clk;
  logic rst_n;

  bbc_in_if  in_ch();
  bbc_out_if out_ch();

  bracket_balance_checker_top #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Words waiting to be offered, and verdicts waiting to arrive
  word_t    feed_q[$];
  verdict_t verdict_q[$];

  // Own copy of the bracket stack
  br_code_t    nest_stack[STACK_DEPTH];
  int unsigned nest_depth  = 0;
  status_t     latched_err = ST_OK;

  int unsigned cycle_count  = 0;
  int unsigned err_count    = 0;
  int unsigned words_added  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_seen;
  int unsigned hold_left;

  // Clock, with every input known from time zero
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.symbol = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 100) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Bracket tracking for one accepted word; queues a verdict on the final byte
  task automatic track_word(input logic [SYM_W-1:0] sym, input logic fin);
    br_code_t opener;
    br_code_t closer;
    verdict_t v;
    opener = BR_NONE;
    closer = BR_NONE;
    case (sym)
      CH_LPAREN: opener = BR_PAREN;
      CH_LBRACE: opener = BR_BRACE;
      CH_LBRACK: opener = BR_BRACK;
      CH_RPAREN: closer = BR_PAREN;
      CH_RBRACE: closer = BR_BRACE;
      CH_RBRACK: closer = BR_BRACK;
      default: ;
    endcase
    // once an error is held, bytes are not looked at
    if (latched_err == ST_OK) begin
      if (opener != BR_NONE) begin
        if (nest_depth >= STACK_DEPTH) begin
          latched_err = ST_OVERFLOW;
        end else begin
          nest_stack[nest_depth] = opener;
          nest_depth++;
        end
      end else if (closer != BR_NONE) begin
        if (nest_depth == 0) begin
          latched_err = ST_UNMATCHED;
        end else if (nest_stack[nest_depth-1] == closer) begin
          nest_depth--;
        end else begin
          latched_err = ST_MISMATCH;
        end
      end
    end
    if (fin) begin
      v.status = latched_err;
      if (v.status == ST_OK && nest_depth != 0) begin
        v.status = ST_UNCLOSED;
      end
      v.balanced = (v.status == ST_OK);
      verdict_q.push_back(v);
      nest_depth  = 0;
      latched_err = ST_OK;
    end
  endtask

  function automatic logic [SYM_W-1:0] opener_byte(br_code_t k);
    case (k)
      BR_PAREN: return CH_LPAREN;
      BR_BRACE: return CH_LBRACE;
      default:  return CH_LBRACK;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] closer_byte(br_code_t k);
    case (k)
      BR_PAREN: return CH_RPAREN;
      BR_BRACE: return CH_RBRACE;
      default:  return CH_RBRACK;
    endcase
  endfunction

  // Byte weighted towards brackets
  function automatic logic [SYM_W-1:0] any_byte();
    br_code_t k;
    k = br_code_t'($urandom_range(1, 3));
    case ($urandom_range(0, 3))
      0:       return opener_byte(k);
      1:       return closer_byte(k);
      default: return SYM_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_word(input logic [SYM_W-1:0] sym, input logic fin);
    word_t w;
    w.symbol = sym;
    w.last   = fin;
    feed_q.push_back(w);
    words_added++;
  endtask

  // Build one expression of the given shape and queue it, last flag on its final byte
  task automatic gen_expr(input shape_t shape, input int unsigned depth_cap,
                          input int unsigned pre_push);
    br_code_t         opened[$];
    logic [SYM_W-1:0] chars[$];
    br_code_t         k;
    int unsigned      steps;
    int unsigned      r;
    // optional straight run of opens to reach the deep end of the stack
    repeat (pre_push) begin
      k = br_code_t'($urandom_range(1, 3));
      opened.push_back(k);
      chars.push_back(opener_byte(k));
    end
    // well-formed random walk with filler bytes
    steps = $urandom_range(0, 2 * depth_cap + 2);
    repeat (steps) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        chars.push_back(SYM_W'($urandom_range(0, 255)));
      end else if ((r < 55 || opened.size() == 0) && opened.size() < depth_cap) begin
        k = br_code_t'($urandom_range(1, 3));
        opened.push_back(k);
        chars.push_back(opener_byte(k));
      end else if (opened.size() != 0) begin
        chars.push_back(closer_byte(opened.pop_back()));
      end
    end
    // finish according to the shape asked for
    case (shape)
      SHAPE_BALANCED: begin
        while (opened.size() != 0) chars.push_back(closer_byte(opened.pop_back()));
      end
      SHAPE_UNCLOSED: begin
        if (opened.size() == 0) begin
          k = br_code_t'($urandom_range(1, 3));
          opened.push_back(k);
          chars.push_back(opener_byte(k));
        end
        while (opened.size() > 1 && $urandom_range(0, 1) == 1) begin
          chars.push_back(closer_byte(opened.pop_back()));
        end
      end
      SHAPE_MISMATCH: begin
        if (opened.size() == 0) begin
          k = br_code_t'($urandom_range(1, 3));
          opened.push_back(k);
          chars.push_back(opener_byte(k));
        end
        k = opened[$];
        chars.push_back(closer_byte(br_code_t'(k % 3 + 1)));
      end
      SHAPE_UNMATCHED: begin
        while (opened.size() != 0) chars.push_back(closer_byte(opened.pop_back()));
        chars.push_back(closer_byte(br_code_t'($urandom_range(1, 3))));
      end
      SHAPE_OVERFLOW: begin
        while (opened.size() <= STACK_DEPTH) begin
          k = br_code_t'($urandom_range(1, 3));
          opened.push_back(k);
          chars.push_back(opener_byte(k));
        end
      end
      default: begin
        repeat ($urandom_range(1, 6)) chars.push_back(any_byte());
      end
    endcase
    // bytes after an error should be ignored; filler may also close a good one
    if (shape inside {SHAPE_MISMATCH, SHAPE_UNMATCHED, SHAPE_OVERFLOW} &&
        $urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 4)) chars.push_back(any_byte());
    end else if ($urandom_range(0, 3) == 0) begin
      chars.push_back(SYM_W'($urandom_range(0, 255)));
    end
    if (chars.size() == 0) begin
      chars.push_back(SYM_W'($urandom_range(0, 255)));
    end
    foreach (chars[i]) add_word(chars[i], i == chars.size() - 1);
  endtask

  // Random expressions, mostly shallow, now and then right up to the stack depth
  task automatic fill_random(input int unsigned n_words);
    int unsigned goal;
    int unsigned r;
    int unsigned cap;
    int unsigned pre;
    shape_t      shape;
    goal = words_added + n_words;
    while (words_added < goal) begin
      r = $urandom_range(0, 99);
      if (r < 48)      shape = SHAPE_BALANCED;
      else if (r < 60) shape = SHAPE_UNCLOSED;
      else if (r < 72) shape = SHAPE_MISMATCH;
      else if (r < 82) shape = SHAPE_UNMATCHED;
      else if (r < 85) shape = SHAPE_OVERFLOW;
      else             shape = SHAPE_NOISE;
      cap = ($urandom_range(0, 24) == 0) ? STACK_DEPTH : $urandom_range(1, 8);
      pre = (cap == STACK_DEPTH) ? $urandom_range(STACK_DEPTH - 6, STACK_DEPTH) : 0;
      gen_expr(shape, cap, pre);
    end
  endtask

  task automatic wait_feed_empty();
    while (feed_q.size() != 0) @(negedge clk);
  endtask

  // Input driver: holds a word until taken, predicts on acceptance
  always @(posedge clk) begin : drive_in
    word_t nxt;
    logic  take;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      take = (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
      if (take) begin
        track_word(in_ch.symbol, in_ch.last);
      end
      if (!in_ch.valid || take) begin
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = feed_q.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.symbol <= nxt.symbol;
          in_ch.last   <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Verdict monitor
  always @(posedge clk) begin : watch_out
    verdict_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict balanced=%0b status=%0d with none expected",
                                  out_ch.balanced, out_ch.status));
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.balanced !== want.balanced) begin
          report_mismatch($sformatf("balanced %0b, expected %0b",
                                    out_ch.balanced, want.balanced));
        end
        if (out_ch.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_ch.status, want.status));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, verdict_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender idles lightly, receiver stalls heavily
    tx_idle_pct  = 12;
    rx_stall_pct = 62;

    // extremes of the byte, filler only
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b1);
    // simple pair, final byte a bracket
    add_word(CH_LPAREN, 1'b0);
    add_word(CH_RPAREN, 1'b1);
    // nested brace and bracket around filler
    add_word(CH_LBRACE, 1'b0);
    add_word(CH_LBRACK, 1'b0);
    add_word(8'h41, 1'b0);
    add_word(CH_RBRACK, 1'b0);
    add_word(CH_RBRACE, 1'b1);
    // close on an empty stack as the only byte
    add_word(CH_RPAREN, 1'b1);
    // mismatched pair, later bytes ignored
    add_word(CH_LPAREN, 1'b0);
    add_word(CH_RBRACK, 1'b0);
    add_word(CH_LPAREN, 1'b0);
    add_word(8'h7E, 1'b1);
    // opens left at the end
    add_word(CH_LBRACK, 1'b0);
    add_word(CH_LPAREN, 1'b1);
    // error held: final close is not examined
    add_word(CH_RBRACK, 1'b0);
    add_word(CH_LPAREN, 1'b0);
    add_word(CH_RPAREN, 1'b1);
    // unclosed with filler as final byte
    add_word(CH_LBRACE, 1'b0);
    add_word(8'h80, 1'b1);

    // stack filled exactly, then one push too many
    gen_expr(SHAPE_BALANCED, STACK_DEPTH, STACK_DEPTH);
    gen_expr(SHAPE_OVERFLOW, 8, 0);
    fill_random(530);
    wait_feed_empty();

    // the other way round
    tx_idle_pct  = 62;
    rx_stall_pct = 12;
    fill_random(530);
    wait_feed_empty();

    // no idling, with one long receiver hold-off so the input backs up
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = hold_req + 1;
    fill_random(530);
    wait_feed_empty();

    while (in_ch.valid === 1'b1 || verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: bracket_balance_checker_top.f
rtl/bbc_pkg.sv
rtl/bbc_if.sv
rtl/bbc_front.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker_top.sv
rtl/bbc_checker.sv
dv/bracket_balance_checker_top_test.sv
